// ===== rtl/acpa_pkg.sv =====
// Shared types, constants and helper functions for the aligned contiguous page allocator.
// Depends on nothing. Used by the allocator core and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package acpa_pkg;

  localparam int unsigned MAX_AREA_PAGES_DEF = 4096;

  localparam int unsigned FRAME_W     = 36;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned ORDER_W     = 5;
  localparam int unsigned MAX_ORDER_W = 4;
  localparam int unsigned AREA_W      = 13;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned LOG_WORD  = 6;

  localparam int unsigned ADD_W = FRAME_W + 1;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_AREA  = 2'd1;
  localparam logic [1:0] REG_ALIGN = 2'd2;

  localparam logic [MAX_ORDER_W-1:0] MAX_ORDER_RESET = 4'd8;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FAIL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic [COUNT_W-1:0] page_count;
    logic [ORDER_W-1:0] align_order;
    logic [FRAME_W-1:0] release_frame;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] alloc_frame;
  } rsp_t;

  // Index of the lowest set bit; all ones when no bit is set.
  function automatic logic [LOG_WORD-1:0] first_one(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] x;
    logic [LOG_WORD-1:0]  idx;
    int                   k;
    x   = v;
    idx = '0;
    for (k = LOG_WORD - 1; k >= 0; k--) begin
      if ((x & ((WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1))) == '0) begin
        idx[k] = 1'b1;
        x      = x >> (1 << k);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/acpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing; holds the page bitmap words of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module acpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/aligned_contiguous_page_allocator_core.sv =====
// Aligned contiguous page allocator: bitmap over one page area, first-fit aligned runs.
// Depends on acpa_pkg and acpa_ram.
// Flow: allocate fails at once for a zero count or an empty area; else it fits a candidate run,
//   reads and checks its bitmap words, skips to the next aligned candidate on a hit, then marks
//   the run word by word and forms the frame; release checks the range, then clears its pages
//   word by word. One transfer in flight; the next is taken in the cycle the result is presented.
// Reset: a clearing pass writes MAX_AREA_PAGES/64 words, stall held.
`timescale 1ns / 1ps
`default_nettype none

module aligned_contiguous_page_allocator_core import acpa_pkg::*; #(
  parameter int unsigned MAX_AREA_PAGES = MAX_AREA_PAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  req_valid_i,
  output logic                       req_stall_o,
  input  wire req_t                  req_i,
  output logic                       rsp_valid_o,
  input  wire logic                  rsp_stall_i,
  output rsp_t                       rsp_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned MAP_WORDS = (MAX_AREA_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned AW = $clog2(MAX_AREA_PAGES + 1);
  localparam int unsigned SW = ((AW > 16) ? AW : 16) + 1;
  localparam logic [SW-1:0] MAX_PAGES = SW'(MAX_AREA_PAGES);
  localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_AFIT  = 4'd2;
  localparam logic [3:0] ST_SRD   = 4'd3;
  localparam logic [3:0] ST_SCHK  = 4'd4;
  localparam logic [3:0] ST_SADV  = 4'd5;
  localparam logic [3:0] ST_RLIM  = 4'd6;
  localparam logic [3:0] ST_ROFF  = 4'd7;
  localparam logic [3:0] ST_REND  = 4'd8;
  localparam logic [3:0] ST_MRD   = 4'd9;
  localparam logic [3:0] ST_MWR   = 4'd10;
  localparam logic [3:0] ST_FRAME = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  // configuration registers
  logic [FRAME_W-1:0]     base_q;
  logic [AREA_W-1:0]      area_q;
  logic [MAX_ORDER_W-1:0] max_order_q;
  logic                   apb_wr;

  // control
  logic [3:0]    state_q, state_d;
  logic [WW-1:0] clr_q, clr_d;
  logic          rsp_valid_q, rsp_valid_d;
  rsp_t          rsp_q, rsp_d;

  // working registers
  cmd_e                   cmd_q, cmd_d;
  logic [COUNT_W-1:0]     cnt_q, cnt_d;
  logic [MAX_ORDER_W-1:0] order_q, order_d;
  logic [FRAME_W-1:0]     rel_q, rel_d;
  logic [SW-1:0]          p_q, p_d;
  logic [SW-1:0]          i_q, i_d;
  logic [SW-1:0]          end_q, end_d;
  logic [SW-1:0]          hit_q, hit_d;
  status_e                status_q, status_d;
  logic [FRAME_W-1:0]     frame_q, frame_d;

  // shared adder
  logic [ADD_W-1:0] add_a, add_b, add_sum;
  logic             add_sub;

  // datapath
  logic                 req_accept;
  logic [SW-1:0]        area_eff;
  logic [SW-1:0]        step;
  logic [SW-1:0]        word_base, word_end, lim;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, run_mask, hits;
  logic [ADD_W-1:0]     rel_hi;
  logic [WW-1:0]        word_addr;
  logic                 ram_we;
  logic [WW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  assign pready = 1'b1;
  assign apb_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      area_q      <= '0;
      max_order_q <= MAX_ORDER_RESET;
    end else if (apb_wr) begin
      unique case (paddr[APB_ADDR_W-1:3])
        REG_BASE:  base_q      <= pwdata[FRAME_W-1:0];
        REG_AREA:  area_q      <= pwdata[AREA_W-1:0];
        REG_ALIGN: max_order_q <= pwdata[MAX_ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1:3])
      REG_BASE:  prdata = APB_DATA_W'(base_q);
      REG_AREA:  prdata = APB_DATA_W'(area_q);
      REG_ALIGN: prdata = APB_DATA_W'(max_order_q);
      default:   prdata = '0;
    endcase
  end

  assign area_eff = (SW'(area_q) > MAX_PAGES) ? MAX_PAGES : SW'(area_q);
  assign step     = SW'(1) << order_q;

  // word window for the current position
  assign word_base = {i_q[SW-1:LOG_WORD], LOG_WORD'(0)};
  assign word_end  = word_base + SW'(WORD_BITS);
  assign lim       = (end_q < word_end) ? end_q : word_end;
  assign lo_mask   = {WORD_BITS{1'b1}} << i_q[LOG_WORD-1:0];
  assign hi_mask   = (lim == word_end) ? {WORD_BITS{1'b1}}
                                       : ~({WORD_BITS{1'b1}} << lim[LOG_WORD-1:0]);
  assign run_mask  = lo_mask & hi_mask;
  assign hits      = ram_rdata & run_mask;
  assign word_addr = WW'(i_q >> LOG_WORD);

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      ST_AFIT: begin
        add_a = ADD_W'(p_q);
        add_b = ADD_W'(cnt_q);
      end
      ST_SADV: begin
        add_a = ADD_W'(hit_q);
        add_b = ADD_W'(step);
      end
      ST_RLIM: begin
        add_a = ADD_W'(base_q);
        add_b = ADD_W'(area_eff);
      end
      ST_ROFF: begin
        add_a   = ADD_W'(rel_q);
        add_b   = ADD_W'(base_q);
        add_sub = 1'b1;
      end
      ST_REND: begin
        add_a = ADD_W'(i_q);
        add_b = ADD_W'(cnt_q);
      end
      ST_FRAME: begin
        add_a = ADD_W'(base_q);
        add_b = ADD_W'(p_q);
      end
      default: ;
    endcase
  end

  assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign rel_hi  = (add_sum < ADD_W'(area_eff)) ? add_sum : ADD_W'(area_eff);

  assign req_stall_o = (state_q != ST_IDLE);
  assign req_accept  = req_valid_i & ~req_stall_o;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rsp_valid_d = rsp_valid_q & rsp_stall_i;
    rsp_d       = rsp_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    order_d     = order_q;
    rel_d       = rel_q;
    p_d         = p_q;
    i_d         = i_q;
    end_d       = end_q;
    hit_d       = hit_q;
    status_d    = status_q;
    frame_d     = frame_q;
    ram_we      = 1'b0;
    ram_waddr   = word_addr;
    ram_wdata   = '0;

    unique case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + WW'(1);
        end
      end
      ST_IDLE: begin
        if (req_accept) begin
          cmd_d    = req_i.command;
          cnt_d    = req_i.page_count;
          rel_d    = req_i.release_frame;
          order_d  = (req_i.align_order > ORDER_W'(max_order_q)) ? max_order_q
                                                                  : req_i.align_order[MAX_ORDER_W-1:0];
          p_d      = '0;
          i_d      = '0;
          status_d = STAT_OK;
          frame_d  = '0;
          if (req_i.command == CMD_RELEASE) begin
            state_d = ST_RLIM;
          end else if (req_i.page_count == '0 || area_q == '0) begin
            status_d = STAT_FAIL;
            state_d  = ST_DONE;
          end else begin
            state_d = ST_AFIT;
          end
        end
      end
      ST_AFIT: begin
        end_d = add_sum[SW-1:0];
        i_d   = p_q;
        if (add_sum > ADD_W'(area_eff)) begin
          status_d = STAT_FAIL;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        state_d = ST_SCHK;
      end
      ST_SCHK: begin
        if (hits != '0) begin
          hit_d   = {i_q[SW-1:LOG_WORD], first_one(hits)};
          state_d = ST_SADV;
        end else if (lim == end_q) begin
          i_d     = p_q;
          state_d = ST_MRD;
        end else begin
          i_d     = lim;
          state_d = ST_SRD;
        end
      end
      ST_SADV: begin
        p_d     = add_sum[SW-1:0] & ~(step - SW'(1));
        state_d = ST_AFIT;
      end
      ST_RLIM: begin
        if (rel_q < base_q || ADD_W'(rel_q) >= add_sum) begin
          status_d = STAT_RANGE;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_ROFF;
        end
      end
      ST_ROFF: begin
        i_d     = add_sum[SW-1:0];
        state_d = ST_REND;
      end
      ST_REND: begin
        end_d = rel_hi[SW-1:0];
        if (rel_hi == ADD_W'(i_q)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MRD;
        end
      end
      ST_MRD: begin
        state_d = ST_MWR;
      end
      ST_MWR: begin
        ram_we    = 1'b1;
        ram_wdata = (cmd_q == CMD_ALLOC) ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);
        i_d       = lim;
        if (lim == end_q) begin
          state_d = (cmd_q == CMD_ALLOC) ? ST_FRAME : ST_DONE;
        end else begin
          state_d = ST_MRD;
        end
      end
      ST_FRAME: begin
        frame_d = add_sum[FRAME_W-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = status_q;
          rsp_d.alloc_frame = frame_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q    <= rsp_d;
    cmd_q    <= cmd_d;
    cnt_q    <= cnt_d;
    order_q  <= order_d;
    rel_q    <= rel_d;
    p_q      <= p_d;
    i_q      <= i_d;
    end_q    <= end_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    frame_q  <= frame_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  acpa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(word_addr),
    .rdata_o(ram_rdata)
  );

  a_fail_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != STAT_OK) |-> rsp_o.alloc_frame == '0)
    else $error("failed transfer carries a frame");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> req_stall_o)
    else $error("second transfer taken while busy");

  a_scan_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCHK) |-> (i_q < end_q && end_q <= area_eff))
    else $error("scan position outside candidate run");

  a_modify_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MWR) |-> (i_q < end_q && end_q <= area_eff))
    else $error("bitmap update outside run");

endmodule

`default_nettype wire

// ===== dv/tb_aligned_contiguous_page_allocator_core.sv =====
// Self-checking bench for the aligned contiguous page allocator core: directed table, then
// randomized allocate/release traffic per register setting, checked against a local bitmap model.
// Depends on acpa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_aligned_contiguous_page_allocator_core;
  import acpa_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int MAX_PAGES       = MAX_AREA_PAGES_DEF;
  localparam int PHASES          = 11;
  localparam int PHASE_ITEMS     = 56;
  localparam int IDLE_PCT        = 13;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 200;
  localparam int WATCHDOG_CYCLES = 100000;

  localparam bit FROM_TABLE = 1'b1;
  localparam bit FROM_MODEL = 1'b0;

  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam logic [FRAME_W-1:0] LOW_BASE  = 36'h0_0000_1000;
  localparam logic [FRAME_W-1:0] HIGH_BASE = 36'hF_FFFF_FF00;

  typedef struct {
    bit          cfg_write;
    logic [1:0]  reg_idx;
    logic [63:0] reg_val;
    req_t        req;
    bit          typed;
    rsp_t        rsp;
  } plan_row_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] pages;
  } run_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  req_valid_i;
  logic                  req_stall_o;
  req_t                  req_i;
  logic                  rsp_valid_o;
  logic                  rsp_stall_i;
  rsp_t                  rsp_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic req_typed;
  rsp_t req_typed_rsp;

  // local copy of the allocator state
  bit   [MAX_PAGES-1:0]   page_busy = '0;
  logic [FRAME_W-1:0]     area_base = '0;
  logic [AREA_W-1:0]      area_size = '0;
  logic [MAX_ORDER_W-1:0] align_cap = MAX_ORDER_RESET;

  rsp_t awaited_rsp[$];
  run_t live_runs[$];

  bit calm;
  bit hold_off_req;
  int errors;
  int quiet_cycles;
  int n_checked;
  int n_alloc;
  int n_alloc_ok;
  int n_release;
  int n_release_range;
  int n_settings;

  rsp_t model_rsp;
  rsp_t want;
  run_t placed;

  aligned_contiguous_page_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic rsp_t serve_request(input req_t r);
    rsp_t            res;
    longint unsigned span;
    longint unsigned cnt;
    longint unsigned order;
    longint unsigned step;
    longint unsigned p;
    longint unsigned hit;
    longint unsigned i;
    longint unsigned stop;
    longint unsigned rel;
    res.status      = STAT_FAIL;
    res.alloc_frame = '0;
    span = (area_size > MAX_PAGES) ? MAX_PAGES : area_size;
    cnt  = r.page_count;
    rel  = r.release_frame;
    if (r.command == CMD_ALLOC) begin
      order = (r.align_order > align_cap) ? align_cap : r.align_order;
      step  = 64'd1 << order;
      p     = 0;
      if (span != 0 && cnt != 0) begin
        while (p + cnt <= span) begin
          hit = p + cnt;
          for (i = p; i < p + cnt; i++) begin
            if (page_busy[i]) begin
              hit = i;
              break;
            end
          end
          if (hit == p + cnt) begin
            for (i = p; i < p + cnt; i++) page_busy[i] = 1'b1;
            res.status      = STAT_OK;
            res.alloc_frame = FRAME_W'(area_base + p);
            break;
          end
          p = (hit + step) & ~(step - 1);
        end
      end
    end else if (rel < area_base || rel >= area_base + span) begin
      res.status = STAT_RANGE;
    end else begin
      stop = rel - area_base + cnt;
      if (stop > span) stop = span;
      for (i = rel - area_base; i < stop; i++) page_busy[i] = 1'b0;
      res.status = STAT_OK;
    end
    return res;
  endfunction

  function automatic plan_row_t req_row(input cmd_e cmd, input int pages, input int order,
                                        input logic [FRAME_W-1:0] frame, input bit typed,
                                        input status_e st, input logic [FRAME_W-1:0] got);
    plan_row_t row;
    row.cfg_write             = 1'b0;
    row.reg_idx               = REG_BASE;
    row.reg_val               = '0;
    row.req.command           = cmd;
    row.req.page_count        = COUNT_W'(pages);
    row.req.align_order       = ORDER_W'(order);
    row.req.release_frame     = frame;
    row.typed                 = typed;
    row.rsp.status            = st;
    row.rsp.alloc_frame       = got;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [63:0] val);
    plan_row_t row;
    row.cfg_write = 1'b1;
    row.reg_idx   = idx;
    row.reg_val   = val;
    row.req       = '0;
    row.typed     = 1'b0;
    row.rsp       = '0;
    return row;
  endfunction

  function automatic req_t make_request();
    req_t        r;
    logic [63:0] noise;
    int          k;
    int          roll;
    int          span;
    noise = {$urandom, $urandom};
    roll  = $urandom_range(99);
    span  = (area_size > MAX_PAGES) ? MAX_PAGES : int'(area_size);
    r.command       = CMD_ALLOC;
    r.page_count    = COUNT_W'($urandom_range(1, (span > 12) ? span / 6 : 2));
    r.align_order   = ORDER_W'(($urandom_range(99) < 60) ? $urandom_range(4)
                                                         : $urandom_range(31));
    r.release_frame = noise[FRAME_W-1:0];
    if (roll < 8) begin
      r.page_count = $urandom_range(1) ? '0 : COUNT_W'($urandom_range(MAX_PAGES));
    end else if (roll >= 50) begin
      r.command = CMD_RELEASE;
      if (roll < 85 && live_runs.size() != 0) begin
        k = $urandom_range(live_runs.size() - 1);
        r.release_frame = live_runs[k].frame;
        r.page_count    = live_runs[k].pages;
        if (live_runs[k].pages < 64 && $urandom_range(9) == 0)
          r.page_count = r.page_count + COUNT_W'($urandom_range(8));
        live_runs.delete(k);
      end else begin
        r.page_count = COUNT_W'(($urandom_range(3) == 0) ? $urandom_range(MAX_PAGES)
                                                         : $urandom_range(16));
        if ($urandom_range(1))
          r.release_frame = FRAME_W'(area_base + $urandom_range(span + 1) - 1);
      end
    end
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BASE:  area_base = val[FRAME_W-1:0];
      REG_AREA:  area_size = val[AREA_W-1:0];
      REG_ALIGN: align_cap = val[MAX_ORDER_W-1:0];
      default: ;
    endcase
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic offer(input req_t r, input bit typed, input rsp_t typed_rsp);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i   <= 1'b1;
    req_i         <= r;
    req_typed     <= typed;
    req_typed_rsp <= typed_rsp;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
  endtask

  task automatic drain(input int settle);
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  initial begin : rsp_sink
    int hold_left;
    hold_left = 0;
    rsp_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall_i <= 1'b1;
      end else if (calm) begin
        rsp_stall_i <= 1'b0;
      end else begin
        rsp_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_valid_i && !req_stall_o) begin
      model_rsp = serve_request(req_i);
      if (req_i.command == CMD_ALLOC) begin
        n_alloc++;
        if (model_rsp.status == STAT_OK) begin
          n_alloc_ok++;
          placed.frame = model_rsp.alloc_frame;
          placed.pages = req_i.page_count;
          live_runs.push_back(placed);
        end
      end else begin
        n_release++;
        if (model_rsp.status == STAT_RANGE) n_release_range++;
      end
      awaited_rsp.push_back(req_typed ? req_typed_rsp : model_rsp);
    end
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      n_checked++;
      if (awaited_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, got status %0d frame 'h%h",
                 $time, rsp_o.status, rsp_o.alloc_frame);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_o.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, rsp_o.status);
        end
        if (rsp_o.alloc_frame !== want.alloc_frame) begin
          errors++;
          $display("%0t: alloc_frame mismatch, expected 'h%h, got 'h%h",
                   $time, want.alloc_frame, rsp_o.alloc_frame);
        end
      end
    end
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                 $time, quiet_cycles, awaited_rsp.size());
        $display("tb_aligned_contiguous_page_allocator_core NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    plan_row_t          plan[$];
    plan_row_t          row;
    logic [63:0]        noise;
    logic [FRAME_W-1:0] phase_base;
    int                 phase_pages;
    int                 phase_align;
    int                 idx;
    int                 ph;
    int                 n;

    req_valid_i   <= 1'b0;
    req_i         <= '0;
    req_typed     <= 1'b0;
    req_typed_rsp <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    // empty area
    plan.push_back(req_row(CMD_ALLOC,   1, 0, '0, FROM_TABLE, STAT_FAIL,  '0));
    plan.push_back(req_row(CMD_RELEASE, 1, 0, '0, FROM_TABLE, STAT_RANGE, '0));
    plan.push_back(cfg_row(REG_BASE, 64'(LOW_BASE)));
    plan.push_back(cfg_row(REG_AREA, 64'd64));
    // zero count, oversized count, field extremes, first placement
    plan.push_back(req_row(CMD_ALLOC, 0,  0, '0, FROM_TABLE, STAT_FAIL, '0));
    plan.push_back(req_row(CMD_ALLOC, 65, 0, '0, FROM_TABLE, STAT_FAIL, '0));
    plan.push_back(req_row(CMD_ALLOC, MAX_PAGES, 31, FRAME_MAX, FROM_TABLE, STAT_FAIL, '0));
    plan.push_back(req_row(CMD_ALLOC, 1, 0, '0, FROM_TABLE, STAT_OK, LOW_BASE));
    plan.push_back(req_row(CMD_ALLOC, 3, 2, '0, FROM_MODEL, STAT_OK, '0));
    plan.push_back(req_row(CMD_ALLOC, 5, 31, '0, FROM_MODEL, STAT_OK, '0));
    // release bounds, zero count, past the end, free pages
    plan.push_back(req_row(CMD_RELEASE, 1, 0, LOW_BASE - 1, FROM_TABLE, STAT_RANGE, '0));
    plan.push_back(req_row(CMD_RELEASE, 1, 0, LOW_BASE + 64, FROM_TABLE, STAT_RANGE, '0));
    plan.push_back(req_row(CMD_RELEASE, 0, 0, LOW_BASE + 4, FROM_TABLE, STAT_OK, '0));
    plan.push_back(req_row(CMD_RELEASE, MAX_PAGES, 0, LOW_BASE + 60, FROM_TABLE, STAT_OK, '0));
    plan.push_back(req_row(CMD_RELEASE, 64, 0, LOW_BASE, FROM_TABLE, STAT_OK, '0));
    plan.push_back(req_row(CMD_ALLOC, 64, 0, '0, FROM_TABLE, STAT_OK, LOW_BASE));
    plan.push_back(req_row(CMD_RELEASE, 64, 0, LOW_BASE, FROM_TABLE, STAT_OK, '0));
    // alignment clamp at both ends
    plan.push_back(cfg_row(REG_ALIGN, 64'd0));
    plan.push_back(req_row(CMD_ALLOC, 1, 31, '0, FROM_MODEL, STAT_OK, '0));
    plan.push_back(req_row(CMD_ALLOC, 2, 16, '0, FROM_MODEL, STAT_OK, '0));
    plan.push_back(cfg_row(REG_ALIGN, 64'd12));
    // oversized area, frame wrap, area change keeps the map
    plan.push_back(cfg_row(REG_AREA, 64'd8191));
    plan.push_back(cfg_row(REG_BASE, 64'(HIGH_BASE)));
    plan.push_back(req_row(CMD_ALLOC, MAX_PAGES, 0, '0, FROM_MODEL, STAT_OK, '0));
    plan.push_back(req_row(CMD_ALLOC, 200, 12, '0, FROM_MODEL, STAT_OK, '0));
    plan.push_back(req_row(CMD_ALLOC, 300, 1, '0, FROM_MODEL, STAT_OK, '0));
    plan.push_back(req_row(CMD_ALLOC, 1, 8, FRAME_MAX, FROM_MODEL, STAT_OK, '0));
    plan.push_back(req_row(CMD_RELEASE, MAX_PAGES, 0, FRAME_MAX, FROM_TABLE, STAT_OK, '0));
    plan.push_back(req_row(CMD_RELEASE, 1, 0, '0, FROM_TABLE, STAT_RANGE, '0));
    plan.push_back(req_row(CMD_RELEASE, MAX_PAGES, 0, HIGH_BASE, FROM_TABLE, STAT_OK, '0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (idx = 0; idx < plan.size(); idx++) begin
      row = plan[idx];
      if (row.cfg_write) begin
        drain(SETTLE_CYCLES);
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer(row.req, row.typed, row.rsp);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain(SETTLE_CYCLES);
      live_runs.delete();
      noise = {$urandom, $urandom};
      case (ph)
        0:          phase_base = '0;
        1:          phase_base = FRAME_MAX - 36'd40;
        PHASES - 1: phase_base = FRAME_MAX;
        default:    phase_base = noise[FRAME_W-1:0];
      endcase
      case (ph)
        0:       phase_pages = 64;
        1:       phase_pages = 128;
        2:       phase_pages = 256;
        3:       phase_pages = 1;
        4:       phase_pages = MAX_PAGES;
        5:       phase_pages = 100;
        6:       phase_pages = 0;
        7:       phase_pages = 512;
        8:       phase_pages = 63;
        9:       phase_pages = 200;
        default: phase_pages = 64;
      endcase
      phase_align = (ph == 0) ? 0 : (ph == 1) ? 12 : $urandom_range(12);
      write_reg(REG_BASE, 64'(phase_base));
      write_reg(REG_AREA, 64'(phase_pages));
      write_reg(REG_ALIGN, 64'(phase_align));
      calm = (ph == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == 8) hold_off_req = 1'b1;
        if (ph == 7 && n == 28) drain(SETTLE_CYCLES);
        offer(make_request(), FROM_MODEL, '0);
      end
      row = req_row(CMD_RELEASE, MAX_PAGES, 0, area_base, FROM_MODEL, STAT_OK, '0);
      offer(row.req, row.typed, row.rsp);
    end
    calm = 1'b0;

    drain(TAIL_CYCLES);
    $display("Ran %0d requests over %0d register writes: %0d allocations (%0d placed),",
             n_alloc + n_release, n_settings, n_alloc, n_alloc_ok);
    $display("%0d releases (%0d outside the area); %0d responses compared, %0d mismatches.",
             n_release, n_release_range, n_checked, errors);
    if (errors == 0) begin
      $display("tb_aligned_contiguous_page_allocator_core OK");
    end else begin
      $display("tb_aligned_contiguous_page_allocator_core NOT OK");
    end
    $finish;
  end

endmodule
